[hw/rtl/wsp_pkg.sv]
// ----------------------------------------------------------------------------
// wsp_pkg
// shared constants, register codes and helpers for the world to screen
// projection block
// ----------------------------------------------------------------------------
package wsp_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int COEF_W        = 32;
  localparam int CFG_DATA_W    = 64;
  localparam int CFG_IDX_W     = 3;
  localparam int SCREEN_W      = 14;
  localparam int CAP_LOG       = 40;
  localparam int Q_BITS        = CAP_LOG + 1;
  localparam int ACC_W         = 44;

  localparam logic [SCREEN_W-1:0] WIDTH_RESET  = SCREEN_W'(1920);
  localparam logic [SCREEN_W-1:0] HEIGHT_RESET = SCREEN_W'(1080);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CLIP_X_LOW  = 3'd0,
    REG_CLIP_X_HIGH = 3'd1,
    REG_CLIP_Y_LOW  = 3'd2,
    REG_CLIP_Y_HIGH = 3'd3,
    REG_CLIP_W_LOW  = 3'd4,
    REG_CLIP_W_HIGH = 3'd5,
    REG_SCREEN_W    = 3'd6,
    REG_SCREEN_H    = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic vis;
    logic neg_x;
    logic neg_y;
    logic ovf_x;
    logic ovf_y;
  } div_flags_t;

  function automatic logic signed [COEF_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] hi;
    logic signed [ACC_W-1:0] lo;
    hi = ACC_W'(32'sh7fffffff);
    lo = -ACC_W'(64'sh80000000);
    if (v > hi) sat32 = 32'sh7fffffff;
    else if (v < lo) sat32 = 32'sh80000000;
    else sat32 = v[COEF_W-1:0];
  endfunction

endpackage

[hw/rtl/wsp_clip_dot.sv]
// ----------------------------------------------------------------------------
// wsp_clip_dot
// one clip coordinate: three fixed point products and an offset, two stages
// ----------------------------------------------------------------------------
module wsp_clip_dot import wsp_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int SUM_W     = 66 - FRAC_BITS
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic signed [COEF_W-1:0] x,
  input  logic signed [COEF_W-1:0] y,
  input  logic signed [COEF_W-1:0] z,
  input  logic signed [COEF_W-1:0] wx,
  input  logic signed [COEF_W-1:0] wy,
  input  logic signed [COEF_W-1:0] wz,
  input  logic signed [COEF_W-1:0] off,
  output logic signed [SUM_W-1:0]  sum
);

  logic signed [2*COEF_W-1:0] px;
  logic signed [2*COEF_W-1:0] py;
  logic signed [2*COEF_W-1:0] pz;
  logic signed [COEF_W-1:0]   off_r;
  logic signed [2*COEF_W-1:0] sx;
  logic signed [2*COEF_W-1:0] sy;
  logic signed [2*COEF_W-1:0] sz;

  // arithmetic shift floors, as required
  assign sx = px >>> FRAC_BITS;
  assign sy = py >>> FRAC_BITS;
  assign sz = pz >>> FRAC_BITS;

  always_ff @(posedge clk) begin
    if (en) begin
      px    <= x * wx;
      py    <= y * wy;
      pz    <= z * wz;
      off_r <= off;
      sum   <= SUM_W'(sx) + SUM_W'(sy) + SUM_W'(sz) + SUM_W'(off_r);
    end
  end

endmodule

[hw/rtl/wsp_div_cell.sv]
// ----------------------------------------------------------------------------
// wsp_div_cell
// one quotient bit of the two restoring dividers, shared divisor
// ----------------------------------------------------------------------------
module wsp_div_cell import wsp_pkg::*; #(
  parameter int RW = 50
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              v_in,
  input  logic [RW-1:0]     d_in,
  input  div_flags_t        f_in,
  input  logic [RW-1:0]     rx_in,
  input  logic [Q_BITS-1:0] lx_in,
  input  logic [Q_BITS-1:0] qx_in,
  input  logic [RW-1:0]     ry_in,
  input  logic [Q_BITS-1:0] ly_in,
  input  logic [Q_BITS-1:0] qy_in,
  output logic              v_out,
  output logic [RW-1:0]     d_out,
  output div_flags_t        f_out,
  output logic [RW-1:0]     rx_out,
  output logic [Q_BITS-1:0] lx_out,
  output logic [Q_BITS-1:0] qx_out,
  output logic [RW-1:0]     ry_out,
  output logic [Q_BITS-1:0] ly_out,
  output logic [Q_BITS-1:0] qy_out
);

  logic [RW:0] tx;
  logic [RW:0] ty;
  logic        gx;
  logic        gy;

  assign tx = {rx_in, lx_in[Q_BITS-1]};
  assign ty = {ry_in, ly_in[Q_BITS-1]};
  assign gx = tx >= {1'b0, d_in};
  assign gy = ty >= {1'b0, d_in};

  always_ff @(posedge clk) begin
    if (rst) begin
      v_out <= 1'b0;
    end else if (en) begin
      v_out <= v_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_out  <= d_in;
      f_out  <= f_in;
      rx_out <= gx ? RW'(tx - {1'b0, d_in}) : RW'(tx);
      ry_out <= gy ? RW'(ty - {1'b0, d_in}) : RW'(ty);
      lx_out <= {lx_in[Q_BITS-2:0], 1'b0};
      ly_out <= {ly_in[Q_BITS-2:0], 1'b0};
      qx_out <= {qx_in[Q_BITS-2:0], gx};
      qy_out <= {qy_in[Q_BITS-2:0], gy};
    end
  end

endmodule

[hw/rtl/world_to_screen_projection.sv]
// ----------------------------------------------------------------------------
// world_to_screen_projection
// perspective projection of world points to viewport pixel coordinates
// ----------------------------------------------------------------------------
// points arrive as world_x/y/z beats on the in channel and leave as
// visible/pixel_x/pixel_y beats on the out channel, one result per point
// throughput: one point per cycle while in_ready is high; each result
// passes through four arithmetic stages, the row of 41 divider cells (one
// quotient bit each) and the output register
// configuration writes go through the cfg channel (always ready) and must
// only be issued while no point is in flight
// reset clears all pipeline valids and loads the identity style matrix and
// a 1920 x 1080 viewport
// a stalled receiver holds the output beat; one more result lands in a skid
// register, after which in_ready drops and the whole pipe holds until the
// output drains
// ----------------------------------------------------------------------------
module world_to_screen_projection import wsp_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [COEF_W-1:0]     world_x,
  input  logic signed [COEF_W-1:0]     world_y,
  input  logic signed [COEF_W-1:0]     world_z,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         visible,
  output logic signed [COEF_W-1:0]     pixel_x,
  output logic signed [COEF_W-1:0]     pixel_y,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_DATA_W-1:0]        cfg_data
);

  localparam int SUM_W     = 66 - FRAC_BITS;
  localparam int RW        = SUM_W;
  localparam int PROD_W    = SUM_W + SCREEN_W;
  localparam int DW        = PROD_W + FRAC_BITS - 1;
  localparam int CMP_W     = RW + Q_BITS;
  localparam int W_MIN_RAW = ((1 << FRAC_BITS) + 500) / 1000;
  localparam int W_MIN     = (W_MIN_RAW < 1) ? 1 : W_MIN_RAW;
  localparam logic [CFG_DATA_W-1:0] ONE = CFG_DATA_W'(1) << FRAC_BITS;
  localparam logic [Q_BITS-1:0]     CAP = Q_BITS'(1) << CAP_LOG;

  // configuration registers
  logic [CFG_DATA_W-1:0] cx_lo, cx_hi, cy_lo, cy_hi, cw_lo, cw_hi;
  logic [SCREEN_W-1:0]   scr_w, scr_h;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cx_lo <= ONE;
      cx_hi <= '0;
      cy_lo <= ONE << COEF_W;
      cy_hi <= '0;
      cw_lo <= '0;
      cw_hi <= ONE << COEF_W;
      scr_w <= WIDTH_RESET;
      scr_h <= HEIGHT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_e'(cfg_index))
        REG_CLIP_X_LOW:  cx_lo <= cfg_data;
        REG_CLIP_X_HIGH: cx_hi <= cfg_data;
        REG_CLIP_Y_LOW:  cy_lo <= cfg_data;
        REG_CLIP_Y_HIGH: cy_hi <= cfg_data;
        REG_CLIP_W_LOW:  cw_lo <= cfg_data;
        REG_CLIP_W_HIGH: cw_hi <= cfg_data;
        REG_SCREEN_W:    scr_w <= cfg_data[SCREEN_W-1:0];
        REG_SCREEN_H:    scr_h <= cfg_data[SCREEN_W-1:0];
        default: ;
      endcase
    end
  end

  // pipe advance
  logic adv;
  logic skid_v;
  assign adv      = !skid_v;
  assign in_ready = adv;

  logic v_a, v_b, v_c, v_d;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_a <= 1'b0;
      v_b <= 1'b0;
      v_c <= 1'b0;
      v_d <= 1'b0;
    end else if (adv) begin
      v_a <= in_valid;
      v_b <= v_a;
      v_c <= v_b;
      v_d <= v_c;
    end
  end

  // clip sums
  logic signed [SUM_W-1:0] sum_x, sum_y, sum_w;

  wsp_clip_dot #(.FRAC_BITS(FRAC_BITS), .SUM_W(SUM_W)) u_dot_x (
    .clk(clk), .en(adv), .x(world_x), .y(world_y), .z(world_z),
    .wx(cx_lo[COEF_W-1:0]), .wy(cx_lo[2*COEF_W-1:COEF_W]),
    .wz(cx_hi[COEF_W-1:0]), .off(cx_hi[2*COEF_W-1:COEF_W]), .sum(sum_x)
  );

  wsp_clip_dot #(.FRAC_BITS(FRAC_BITS), .SUM_W(SUM_W)) u_dot_y (
    .clk(clk), .en(adv), .x(world_x), .y(world_y), .z(world_z),
    .wx(cy_lo[COEF_W-1:0]), .wy(cy_lo[2*COEF_W-1:COEF_W]),
    .wz(cy_hi[COEF_W-1:0]), .off(cy_hi[2*COEF_W-1:COEF_W]), .sum(sum_y)
  );

  wsp_clip_dot #(.FRAC_BITS(FRAC_BITS), .SUM_W(SUM_W)) u_dot_w (
    .clk(clk), .en(adv), .x(world_x), .y(world_y), .z(world_z),
    .wx(cw_lo[COEF_W-1:0]), .wy(cw_lo[2*COEF_W-1:COEF_W]),
    .wz(cw_hi[COEF_W-1:0]), .off(cw_hi[2*COEF_W-1:COEF_W]), .sum(sum_w)
  );

  // magnitude times viewport size
  logic [SUM_W-1:0] mag_x, mag_y;
  assign mag_x = sum_x[SUM_W-1] ? SUM_W'(-sum_x) : SUM_W'(sum_x);
  assign mag_y = sum_y[SUM_W-1] ? SUM_W'(-sum_y) : SUM_W'(sum_y);

  logic [PROD_W-1:0] prod_x, prod_y;
  logic [RW-1:0]     w_c;
  logic              vis_c, neg_x_c, neg_y_c;

  always_ff @(posedge clk) begin
    if (adv) begin
      prod_x  <= PROD_W'(mag_x) * PROD_W'(scr_w);
      prod_y  <= PROD_W'(mag_y) * PROD_W'(scr_h);
      w_c     <= RW'(sum_w);
      vis_c   <= sum_w >= SUM_W'(W_MIN);
      neg_x_c <= sum_x[SUM_W-1];
      neg_y_c <= sum_y[SUM_W-1];
    end
  end

  // overflow check and divider load
  logic [DW-1:0]    dx, dy;
  logic [CMP_W-1:0] lim;
  assign dx  = {prod_x, {(FRAC_BITS-1){1'b0}}};
  assign dy  = {prod_y, {(FRAC_BITS-1){1'b0}}};
  assign lim = {w_c, {Q_BITS{1'b0}}};

  logic [RW-1:0]     d_n  [0:Q_BITS];
  div_flags_t        f_n  [0:Q_BITS];
  logic [RW-1:0]     rx_n [0:Q_BITS];
  logic [Q_BITS-1:0] lx_n [0:Q_BITS];
  logic [Q_BITS-1:0] qx_n [0:Q_BITS];
  logic [RW-1:0]     ry_n [0:Q_BITS];
  logic [Q_BITS-1:0] ly_n [0:Q_BITS];
  logic [Q_BITS-1:0] qy_n [0:Q_BITS];
  logic              v_n  [0:Q_BITS];

  assign v_n[0] = v_d;

  always_ff @(posedge clk) begin
    if (adv) begin
      d_n[0]        <= w_c;
      f_n[0].vis    <= vis_c;
      f_n[0].neg_x  <= neg_x_c;
      f_n[0].neg_y  <= neg_y_c;
      f_n[0].ovf_x  <= CMP_W'(dx) >= lim;
      f_n[0].ovf_y  <= CMP_W'(dy) >= lim;
      rx_n[0]       <= RW'(dx >> Q_BITS);
      ry_n[0]       <= RW'(dy >> Q_BITS);
      lx_n[0]       <= dx[Q_BITS-1:0];
      ly_n[0]       <= dy[Q_BITS-1:0];
      qx_n[0]       <= '0;
      qy_n[0]       <= '0;
    end
  end

  for (genvar i = 0; i < Q_BITS; i++) begin : g_cell
    wsp_div_cell #(.RW(RW)) u_cell (
      .clk(clk), .rst(rst), .en(adv),
      .v_in(v_n[i]), .d_in(d_n[i]), .f_in(f_n[i]),
      .rx_in(rx_n[i]), .lx_in(lx_n[i]), .qx_in(qx_n[i]),
      .ry_in(ry_n[i]), .ly_in(ly_n[i]), .qy_in(qy_n[i]),
      .v_out(v_n[i+1]), .d_out(d_n[i+1]), .f_out(f_n[i+1]),
      .rx_out(rx_n[i+1]), .lx_out(lx_n[i+1]), .qx_out(qx_n[i+1]),
      .ry_out(ry_n[i+1]), .ly_out(ly_n[i+1]), .qy_out(qy_n[i+1])
    );
  end

  // cap, viewport map and saturation
  div_flags_t              fl;
  logic [Q_BITS-1:0]       qx_c, qy_c;
  logic signed [ACC_W-1:0] rx, ry, hw, hh, acc_x, acc_y;
  logic                    res_v, res_vis;
  logic signed [COEF_W-1:0] res_px, res_py;

  assign fl    = f_n[Q_BITS];
  assign qx_c  = (fl.ovf_x || qx_n[Q_BITS] > CAP) ? CAP : qx_n[Q_BITS];
  assign qy_c  = (fl.ovf_y || qy_n[Q_BITS] > CAP) ? CAP : qy_n[Q_BITS];
  assign rx    = fl.neg_x ? -$signed(ACC_W'(qx_c)) : $signed(ACC_W'(qx_c));
  assign ry    = fl.neg_y ? -$signed(ACC_W'(qy_c)) : $signed(ACC_W'(qy_c));
  assign hw    = $signed(ACC_W'({scr_w, {(FRAC_BITS-1){1'b0}}}));
  assign hh    = $signed(ACC_W'({scr_h, {(FRAC_BITS-1){1'b0}}}));
  assign acc_x = hw + rx;
  assign acc_y = hh - ry;

  assign res_v   = v_n[Q_BITS] && adv;
  assign res_vis = fl.vis;
  assign res_px  = fl.vis ? sat32(acc_x) : '0;
  assign res_py  = fl.vis ? sat32(acc_y) : '0;

  // output register with skid
  logic                     skid_vis;
  logic signed [COEF_W-1:0] skid_px, skid_py;
  logic                     take;
  assign take = out_ready || !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_v    <= 1'b0;
    end else if (take) begin
      if (skid_v) begin
        out_valid <= 1'b1;
        skid_v    <= 1'b0;
      end else begin
        out_valid <= res_v;
      end
    end else if (res_v) begin
      skid_v <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      if (skid_v) begin
        visible <= skid_vis;
        pixel_x <= skid_px;
        pixel_y <= skid_py;
      end else begin
        visible <= res_vis;
        pixel_x <= res_px;
        pixel_y <= res_py;
      end
    end else if (res_v) begin
      skid_vis <= res_vis;
      skid_px  <= res_px;
      skid_py  <= res_py;
    end
  end

  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skid_v |-> out_valid) else $error("skid holds a beat with output empty");

  a_skid_on_stall: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_v) |-> $past(out_valid && !out_ready))
    else $error("skid filled without a stalled output");

  a_hidden_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !visible) |-> (pixel_x == 0 && pixel_y == 0))
    else $error("hidden point with non-zero coordinates");

endmodule
